### rtl/qmsp_pkg.sv
// ---------------------------------------------------------------------------
// qmsp_pkg - shared types and constants for the quad motor speed PID
// Register codes, channel payloads, stage records and the fixed divider
// constants of the gain scaling.
// ---------------------------------------------------------------------------
package qmsp_pkg;

  // Configuration register codes
  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_DUTY_LIMIT     = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_INVERT_MASK    = 3'd5
  } qmsp_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Gains are scaled by 100 = 4 * 25. Drop the factor four with a shift, then
  // divide by 25 through a rounded-up reciprocal. The magnitude after the
  // shift stays below 2**31, so a 36-bit reciprocal shift is exact.
  localparam int unsigned GainDivisor = 100;
  localparam int unsigned DivShift    = 2;
  localparam int unsigned DivOdd      = GainDivisor >> DivShift;
  localparam int unsigned MagW        = 31;
  localparam int unsigned RecipShift  = 36;
  localparam int unsigned QuotW       = 27;
  localparam logic [31:0] Recip =
    32'(((64'd1 << RecipShift) + 64'(DivOdd) - 64'd1) / 64'(DivOdd));

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [14:0]        duty_limit;
    logic [14:0]        integral_limit;
    logic [3:0]         invert_mask;
  } qmsp_cfg_t;

  typedef struct packed {
    logic [1:0]         motor_index;
    logic [15:0]        encoder_count;
    logic signed [15:0] target_counts;
  } qmsp_item_t;

  // After the error stage: three gain products
  typedef struct packed {
    logic [1:0]         motor;
    logic               live;
    logic               stop;
    logic signed [15:0] delta;
    logic signed [32:0] prod_p;
    logic signed [31:0] prod_i;
    logic signed [34:0] prod_d;
  } qmsp_s1_t;

  // After the sum stage: sign and pre-shifted magnitude
  typedef struct packed {
    logic [1:0]         motor;
    logic               live;
    logic               stop;
    logic signed [15:0] delta;
    logic               neg;
    logic [MagW-1:0]    mag;
  } qmsp_s2_t;

  // After the reciprocal multiply: increment magnitude
  typedef struct packed {
    logic [1:0]         motor;
    logic               live;
    logic               stop;
    logic signed [15:0] delta;
    logic               neg;
    logic [QuotW-1:0]   quot;
  } qmsp_s3_t;

  typedef struct packed {
    logic [1:0]         motor_number;
    logic signed [15:0] measured_delta;
    logic signed [15:0] drive_level;
    logic [14:0]        duty;
    logic               dir_forward;
    logic               dir_reverse;
  } qmsp_res_t;

  // Stage advance strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic res;
  } qmsp_adv_t;

endpackage

### rtl/qmsp_if.sv
// ---------------------------------------------------------------------------
// qmsp_if - valid/ready channels of the quad motor speed PID
// Tick request channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface qmsp_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_index;
  logic [15:0]        encoder_count;
  logic signed [15:0] target_counts;

  modport source (output valid, motor_index, encoder_count, target_counts, input ready);
  modport sink   (input valid, motor_index, encoder_count, target_counts, output ready);
endinterface

interface qmsp_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_number;
  logic signed [15:0] measured_delta;
  logic signed [15:0] drive_level;
  logic [14:0]        duty;
  logic               dir_forward;
  logic               dir_reverse;

  modport source (output valid, motor_number, measured_delta, drive_level, duty,
                  dir_forward, dir_reverse, input ready);
  modport sink   (input valid, motor_number, measured_delta, drive_level, duty,
                  dir_forward, dir_reverse, output ready);
endinterface

interface qmsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/qmsp_front.sv
// ---------------------------------------------------------------------------
// qmsp_front - encoder delta, error, clamped integral and gain products
// Holds per-motor count, error sum and previous error.
// ---------------------------------------------------------------------------
module qmsp_front
  import qmsp_pkg::*;
#(
  parameter int NUM_MOTORS    = 4,
  parameter int COUNTER_START = 32768
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qmsp_cfg_t  cfg_i,
  input  logic       clear_hist_i,
  input  qmsp_item_t item_i,
  input  logic       en_i,
  output qmsp_s1_t   s1_o
);

  localparam int MidxW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic [15:0]        last_q    [NUM_MOTORS];
  logic signed [15:0] err_sum_q [NUM_MOTORS];
  logic signed [17:0] prev_q    [NUM_MOTORS];

  logic [MidxW-1:0]   idx;
  logic               live;
  logic               stop;
  logic [15:0]        raw;
  logic signed [15:0] delta;
  logic signed [16:0] err;
  logic signed [17:0] sum;
  logic signed [17:0] lim;
  logic signed [15:0] sum_sat;
  logic signed [18:0] diff;
  qmsp_s1_t           s1_d;
  qmsp_s1_t           s1_q;

  always_comb begin
    idx  = item_i.motor_index[MidxW-1:0];
    live = 32'(item_i.motor_index) < NUM_MOTORS;
    stop = item_i.target_counts == 16'sd0;
    raw  = item_i.encoder_count - last_q[idx];
    if (cfg_i.invert_mask[item_i.motor_index]) begin
      delta = (raw == 16'h8000) ? 16'sh7fff : -$signed(raw);
    end else begin
      delta = $signed(raw);
    end
    err = 17'(item_i.target_counts) - 17'(delta);
    sum = 18'(err_sum_q[idx]) + 18'(err);
    lim = $signed({3'b000, cfg_i.integral_limit});
    if (sum > lim) begin
      sum_sat = lim[15:0];
    end else if (sum < -lim) begin
      sum_sat = 16'(-lim);
    end else begin
      sum_sat = sum[15:0];
    end
    diff = 19'(err) - 19'(prev_q[idx]);

    s1_d.motor  = item_i.motor_index;
    s1_d.live   = live;
    s1_d.stop   = stop;
    s1_d.delta  = live ? delta : 16'sd0;
    s1_d.prod_p = 33'(cfg_i.gain_p) * 33'(err);
    s1_d.prod_i = 32'(cfg_i.gain_i) * 32'(sum_sat);
    s1_d.prod_d = 35'(cfg_i.gain_d) * 35'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        last_q[m]    <= COUNTER_START[15:0];
        err_sum_q[m] <= '0;
        prev_q[m]    <= '0;
      end
    end else if (clear_hist_i) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        err_sum_q[m] <= '0;
        prev_q[m]    <= '0;
      end
    end else if (en_i && live) begin
      last_q[idx] <= item_i.encoder_count;
      if (stop) begin
        err_sum_q[idx] <= '0;
        prev_q[idx]    <= '0;
      end else begin
        err_sum_q[idx] <= sum_sat;
        prev_q[idx]    <= 18'(err);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

### rtl/qmsp_scale.sv
// ---------------------------------------------------------------------------
// qmsp_scale - sum of gain products divided by the gain scale
// Two stages: sum and magnitude, then the reciprocal multiply.
// ---------------------------------------------------------------------------
module qmsp_scale
  import qmsp_pkg::*;
(
  input  logic     clk_i,
  input  qmsp_s1_t s1_i,
  input  logic     en2_i,
  input  logic     en3_i,
  output qmsp_s3_t s3_o
);

  logic signed [35:0] total;
  logic [35:0]        mag;
  qmsp_s2_t           s2_d;
  qmsp_s2_t           s2_q;
  logic [MagW+31:0]   prod;
  qmsp_s3_t           s3_d;
  qmsp_s3_t           s3_q;

  always_comb begin
    total = 36'(s1_i.prod_p) + 36'(s1_i.prod_i) + 36'(s1_i.prod_d);
    mag   = total[35] ? 36'(-total) : 36'(total);
    s2_d.motor = s1_i.motor;
    s2_d.live  = s1_i.live;
    s2_d.stop  = s1_i.stop;
    s2_d.delta = s1_i.delta;
    s2_d.neg   = total[35];
    s2_d.mag   = mag[MagW+DivShift-1:DivShift];
  end

  always_comb begin
    prod = {32'd0, s2_q.mag} * {{MagW{1'b0}}, Recip};
    s3_d.motor = s2_q.motor;
    s3_d.live  = s2_q.live;
    s3_d.stop  = s2_q.stop;
    s3_d.delta = s2_q.delta;
    s3_d.neg   = s2_q.neg;
    s3_d.quot  = prod[RecipShift+QuotW-1:RecipShift];
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      s2_q <= s2_d;
    end
    if (en3_i) begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;

endmodule

### rtl/qmsp_drive.sv
// ---------------------------------------------------------------------------
// qmsp_drive - drive accumulator, duty clamp and result register
// Holds the per-motor signed drive level.
// ---------------------------------------------------------------------------
module qmsp_drive
  import qmsp_pkg::*;
#(
  parameter int NUM_MOTORS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [14:0] duty_limit_i,
  input  qmsp_s3_t    s3_i,
  input  logic        en_i,
  output qmsp_res_t   res_o
);

  localparam int MidxW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic signed [15:0] accum_q [NUM_MOTORS];

  logic [MidxW-1:0]   idx;
  logic signed [28:0] inc;
  logic signed [28:0] sum;
  logic signed [15:0] sat;
  logic signed [15:0] drive;
  logic [16:0]        mag;
  qmsp_res_t          res_d;
  qmsp_res_t          res_q;

  always_comb begin
    idx = s3_i.motor[MidxW-1:0];
    inc = s3_i.neg ? -$signed({2'b00, s3_i.quot}) : $signed({2'b00, s3_i.quot});
    sum = 29'(accum_q[idx]) + inc;
    if (sum > 29'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -29'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
    drive = (s3_i.live && !s3_i.stop) ? sat : 16'sd0;
    mag   = drive[15] ? 17'(-17'(drive)) : 17'(drive);

    res_d.motor_number   = s3_i.motor;
    res_d.measured_delta = s3_i.delta;
    res_d.drive_level    = drive;
    res_d.duty           = (mag > {2'b00, duty_limit_i}) ? duty_limit_i : mag[14:0];
    res_d.dir_forward    = drive > 16'sd0;
    res_d.dir_reverse    = drive[15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        accum_q[m] <= '0;
      end
    end else if (en_i && s3_i.live) begin
      accum_q[idx] <= drive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/quad_motor_speed_pid.sv
// ---------------------------------------------------------------------------
// quad_motor_speed_pid - incremental PID speed control for four motors
// Top level: channels, configuration registers and stage control.
// ---------------------------------------------------------------------------
// Usage:
//   req_i carries one control tick: motor index, raw 16-bit encoder reading
//   and target counts per period (zero stops the motor and clears its PID
//   history). rsp_o returns one result per request: motor number, measured
//   delta, signed drive level, clamped duty and a direction pair.
//   cfg_i writes gains and limits by register index; it is always ready.
//   Writing any gain clears the integral and previous error of every motor.
//   Write configuration only while no request is in flight.
// Timing:
//   A request passes an input register, the error stage, the sum stage, the
//   reciprocal multiply stage and the result register. One request is taken
//   every cycle while the result channel is not stalled; back-pressure from
//   the receiver holds the flow once every stage is occupied.
// Reset and stall:
//   Reset loads register defaults, sets every stored count to COUNTER_START
//   and clears drive and PID history. When the receiver stalls, hold the
//   result; empty stages behind it still fill, so requests keep flowing
//   until every stage is occupied.
// NUM_MOTORS ranges over 1..4.
// ---------------------------------------------------------------------------
module quad_motor_speed_pid
  import qmsp_pkg::*;
#(
  parameter int NUM_MOTORS    = 4,
  parameter int COUNTER_START = 32768
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  qmsp_cfg_if.sink   cfg_i,
  qmsp_req_if.sink   req_i,
  qmsp_rsp_if.source rsp_o
);

  qmsp_cfg_t  cfg_q;
  logic       clear_hist;
  qmsp_item_t item_q;
  logic       v0_q, v1_q, v2_q, v3_q, res_v_q;
  logic       free0, free1, free2, free3, free_res;
  qmsp_adv_t  adv;
  logic       accept;
  qmsp_s1_t   s1;
  qmsp_s3_t   s3;
  qmsp_res_t  res;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_comb begin
    clear_hist = 1'b0;
    if (cfg_i.valid) begin
      unique case (qmsp_reg_e'(cfg_i.index))
        REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: clear_hist = 1'b1;
        default:                            clear_hist = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= 16'sd150;
      cfg_q.gain_i         <= 16'sd10;
      cfg_q.gain_d         <= 16'sd5;
      cfg_q.duty_limit     <= 15'd1000;
      cfg_q.integral_limit <= 15'd1000;
      cfg_q.invert_mask    <= 4'd10;
    end else if (cfg_i.valid) begin
      unique case (qmsp_reg_e'(cfg_i.index))
        REG_GAIN_P:         cfg_q.gain_p         <= cfg_i.data;
        REG_GAIN_I:         cfg_q.gain_i         <= cfg_i.data;
        REG_GAIN_D:         cfg_q.gain_d         <= cfg_i.data;
        REG_DUTY_LIMIT:     cfg_q.duty_limit     <= cfg_i.data[14:0];
        REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_i.data[14:0];
        REG_INVERT_MASK:    cfg_q.invert_mask    <= cfg_i.data[3:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Stage control: a stage advances when its successor is empty or advancing
  always_comb begin
    free_res = !res_v_q || rsp_o.ready;
    adv.res  = v3_q && free_res;
    free3    = !v3_q || adv.res;
    adv.s3   = v2_q && free3;
    free2    = !v2_q || adv.s3;
    adv.s2   = v1_q && free2;
    free1    = !v1_q || adv.s2;
    adv.s1   = v0_q && free1;
    free0    = !v0_q || adv.s1;
  end

  assign req_i.ready = free0;
  assign accept      = req_i.valid && free0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      v0_q    <= accept  || (v0_q && !adv.s1);
      v1_q    <= adv.s1  || (v1_q && !adv.s2);
      v2_q    <= adv.s2  || (v2_q && !adv.s3);
      v3_q    <= adv.s3  || (v3_q && !adv.res);
      res_v_q <= adv.res || (res_v_q && !rsp_o.ready);
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.motor_index   <= req_i.motor_index;
      item_q.encoder_count <= req_i.encoder_count;
      item_q.target_counts <= req_i.target_counts;
    end
  end

  qmsp_front #(
    .NUM_MOTORS    (NUM_MOTORS),
    .COUNTER_START (COUNTER_START)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clear_hist_i (clear_hist),
    .item_i       (item_q),
    .en_i         (adv.s1),
    .s1_o         (s1)
  );

  qmsp_scale u_scale (
    .clk_i (clk_i),
    .s1_i  (s1),
    .en2_i (adv.s2),
    .en3_i (adv.s3),
    .s3_o  (s3)
  );

  qmsp_drive #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_drive (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .duty_limit_i (cfg_q.duty_limit),
    .s3_i         (s3),
    .en_i         (adv.res),
    .res_o        (res)
  );

  assign rsp_o.valid          = res_v_q;
  assign rsp_o.motor_number   = res.motor_number;
  assign rsp_o.measured_delta = res.measured_delta;
  assign rsp_o.drive_level    = res.drive_level;
  assign rsp_o.duty           = res.duty;
  assign rsp_o.dir_forward    = res.dir_forward;
  assign rsp_o.dir_reverse    = res.dir_reverse;

endmodule

### rtl/qmsp_checker.sv
// ---------------------------------------------------------------------------
// qmsp_checker - port-level checks for the quad motor speed PID
// Result channel handshake and consistency of drive, direction and duty.
// ---------------------------------------------------------------------------
module qmsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic signed [15:0] drive_level_i,
  input logic [14:0]        duty_i,
  input logic               dir_forward_i,
  input logic               dir_reverse_i
);

  logic [16:0] drive_mag;

  assign drive_mag = drive_level_i[15] ? 17'(-17'(drive_level_i)) : 17'(drive_level_i);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_drive_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(drive_level_i) && $stable(duty_i))
    else $error("result changed while stalled");

  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (dir_forward_i == (drive_level_i > 16'sd0)) &&
                    (dir_reverse_i == (drive_level_i < 16'sd0)))
    else $error("direction pair disagrees with drive level");

  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> {2'b00, duty_i} <= drive_mag)
    else $error("duty exceeds drive magnitude");

endmodule

bind quad_motor_speed_pid qmsp_checker u_qmsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .drive_level_i (rsp_o.drive_level),
  .duty_i        (rsp_o.duty),
  .dir_forward_i (rsp_o.dir_forward),
  .dir_reverse_i (rsp_o.dir_reverse)
);
